FILE: rtl/qvbb_pkg.sv
package qvbb_pkg;

  localparam int CoordWidthDef = 32;
  localparam int AxesDef       = 3;
  localparam int MaxAxes       = 3;
  localparam int ExtW          = 64;   // widest supported coordinate

  localparam int CompW   = 32;
  localparam int CodeW   = 16;
  localparam int ScaleW  = 32;
  localparam int FieldW  = 32;
  localparam int DimsW   = 2;
  localparam int CfgIdxW = 3;

  // signed code times unsigned scale, then plus offset
  localparam int ProdW = CodeW + ScaleW + 1;
  localparam int SumW  = ProdW + 1;

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(32'h0001_0000);
  localparam logic [DimsW-1:0]  DimsReset  = DimsW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE     = 3'd0,
    CFG_DIMS     = 3'd1,
    CFG_SCALE    = 3'd2,
    CFG_OFFSET_X = 3'd3,
    CFG_OFFSET_Y = 3'd4,
    CFG_OFFSET_Z = 3'd5
  } qvbb_cfg_idx_e;

  typedef struct packed {
    logic ld1;
    logic ld2;
  } qvbb_pipe_ctrl_t;

endpackage

FILE: rtl/qvbb_if.sv
interface qvbb_vtx_if import qvbb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CompW-1:0]  comp_x;
  logic signed [CompW-1:0]  comp_y;
  logic signed [CompW-1:0]  comp_z;
  logic                     last_vertex;

  modport source (output valid, comp_x, comp_y, comp_z, last_vertex, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, last_vertex, output ready);
endinterface

interface qvbb_box_if import qvbb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [FieldW-1:0] min_x;
  logic signed [FieldW-1:0] min_y;
  logic signed [FieldW-1:0] min_z;
  logic signed [FieldW-1:0] max_x;
  logic signed [FieldW-1:0] max_y;
  logic signed [FieldW-1:0] max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface qvbb_cfg_if import qvbb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [FieldW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/quantized_vertex_bounding_box.sv
// channel  | dir | payload                                   | transfer
// cfg_i    | in  | index, data                               | valid && ready (ready tied high)
// vtx_i    | in  | comp_x, comp_y, comp_z, last_vertex       | valid && ready
// box_o    | out | min_x..z, max_x..z                        | valid && ready
//
// Unless stalled, one vertex per cycle; multiply, add/saturate, min/max fold: one stage each.
// A box enters an output register as its last vertex leaves the fold stage and waits there.
// The input stalls only while a last vertex waits in the fold stage behind an untaken box.
// Reset empties the pipe, loads register defaults and arms the running min/max.
module quantized_vertex_bounding_box import qvbb_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDef,
  parameter int AXES        = AxesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qvbb_cfg_if.sink   cfg_i,
  qvbb_vtx_if.sink   vtx_i,
  qvbb_box_if.source box_o
);

  logic                     mode_q;
  logic [DimsW-1:0]         dims_q;
  logic [ScaleW-1:0]        scale_q;
  logic signed [FieldW-1:0] offset_q [MaxAxes];

  logic                     v1_q, l1_q, v2_q, l2_q;
  logic                     out_free, drain2, en1, en2;
  qvbb_pipe_ctrl_t          ctrl;

  logic signed [CompW-1:0]       comps [MaxAxes];
  logic signed [COORD_WIDTH-1:0] vals  [AXES];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      dims_q   <= DimsReset;
      scale_q  <= ScaleReset;
      offset_q <= '{default: '0};
    end else if (cfg_i.valid) begin
      unique case (qvbb_cfg_idx_e'(cfg_i.index))
        CFG_MODE:     mode_q      <= cfg_i.data[0];
        CFG_DIMS:     dims_q      <= cfg_i.data[DimsW-1:0];
        CFG_SCALE:    scale_q     <= cfg_i.data;
        CFG_OFFSET_X: offset_q[0] <= cfg_i.data;
        CFG_OFFSET_Y: offset_q[1] <= cfg_i.data;
        CFG_OFFSET_Z: offset_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // elastic pipe: a stage loads when it is empty or its content moves on
  assign out_free    = !box_o.valid || box_o.ready;
  assign drain2      = v2_q && (!l2_q || out_free);
  assign en2         = !v2_q || drain2;
  assign en1         = !v1_q || en2;
  assign vtx_i.ready = en1;
  assign ctrl.ld1    = en1;
  assign ctrl.ld2    = en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      l1_q <= 1'b0;
      v2_q <= 1'b0;
      l2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= vtx_i.valid;
        l1_q <= vtx_i.last_vertex;
      end
      if (en2) begin
        v2_q <= v1_q;
        l2_q <= l1_q;
      end
    end
  end

  assign comps[0] = vtx_i.comp_x;
  assign comps[1] = vtx_i.comp_y;
  assign comps[2] = vtx_i.comp_z;

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    qvbb_lane #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .mode_i  (mode_q),
      .used_i  (DimsW'(a) < dims_q),
      .comp_i  (comps[a]),
      .scale_i (scale_q),
      .offset_i(offset_q[a]),
      .val_o   (vals[a])
    );
  end

  qvbb_merge #(
    .COORD_WIDTH(COORD_WIDTH),
    .AXES       (AXES)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .drain_i(drain2),
    .last_i (l2_q),
    .val_i  (vals),
    .box_o  (box_o)
  );

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> vtx_i.ready)
    else $error("input stalled with empty first stage");

  a_stage2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !drain2 |=> v2_q && $stable(l2_q))
    else $error("stalled vertex dropped from second stage");

  a_box_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain2 && l2_q |=> box_o.valid)
    else $error("last vertex folded without a box");

  a_box_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(box_o.valid) |-> $past(drain2 && l2_q))
    else $error("box raised without a last vertex");

endmodule

FILE: rtl/qvbb_lane.sv
module qvbb_lane import qvbb_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic                          clk_i,
  input  qvbb_pipe_ctrl_t               ctrl_i,
  input  logic                          mode_i,
  input  logic                          used_i,
  input  logic signed [CompW-1:0]       comp_i,
  input  logic        [ScaleW-1:0]      scale_i,
  input  logic signed [FieldW-1:0]      offset_i,
  output logic signed [COORD_WIDTH-1:0] val_o
);

  localparam logic signed [COORD_WIDTH-1:0] CoordMax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CoordMin = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [CodeW-1:0]       code;
  logic signed [ScaleW:0]        scale_s;
  logic signed [ProdW-1:0]       prod_d, prod_q;
  logic signed [CompW-1:0]       raw_q;
  logic                          used_q;
  logic signed [SumW-1:0]        sum;
  logic signed [SumW-1:0]        pick;
  logic signed [COORD_WIDTH-1:0] sat;
  logic signed [COORD_WIDTH-1:0] val_d, val_q;

  assign code    = comp_i[CodeW-1:0];
  assign scale_s = {1'b0, scale_i};
  assign prod_d  = code * scale_s;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      prod_q <= prod_d;
      raw_q  <= comp_i;
      used_q <= used_i;
    end
  end

  assign sum  = SumW'(prod_q) + SumW'(offset_i);
  assign pick = mode_i ? sum : SumW'(raw_q);

  if (COORD_WIDTH >= SumW) begin : g_wide
    assign sat = COORD_WIDTH'(pick);
  end else begin : g_sat
    logic [SumW-COORD_WIDTH:0] top_bits;
    logic                      ovf;
    assign top_bits = pick[SumW-1:COORD_WIDTH-1];
    assign ovf      = !((&top_bits) || (~|top_bits));
    always_comb begin
      if (ovf) begin
        sat = pick[SumW-1] ? CoordMin : CoordMax;
      end else begin
        sat = pick[COORD_WIDTH-1:0];
      end
    end
  end

  assign val_d = used_q ? sat : '0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld2) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

FILE: rtl/qvbb_merge.sv
module qvbb_merge import qvbb_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDef,
  parameter int AXES        = AxesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          drain_i,
  input  logic                          last_i,
  input  logic signed [COORD_WIDTH-1:0] val_i [AXES],
  qvbb_box_if.source                    box_o
);

  localparam logic signed [COORD_WIDTH-1:0] CoordMax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CoordMin = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [COORD_WIDTH-1:0] run_min_q [AXES];
  logic signed [COORD_WIDTH-1:0] run_max_q [AXES];
  logic signed [COORD_WIDTH-1:0] nmin [AXES];
  logic signed [COORD_WIDTH-1:0] nmax [AXES];
  logic signed [FieldW-1:0]      fmin [MaxAxes];
  logic signed [FieldW-1:0]      fmax [MaxAxes];
  logic signed [FieldW-1:0]      box_min_q [MaxAxes];
  logic signed [FieldW-1:0]      box_max_q [MaxAxes];
  logic                          out_valid_d, out_valid_q;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      nmin[a] = (val_i[a] < run_min_q[a]) ? val_i[a] : run_min_q[a];
      nmax[a] = (val_i[a] > run_max_q[a]) ? val_i[a] : run_max_q[a];
    end
  end

  // result fields keep the low bits of the sign-extended coordinate
  for (genvar a = 0; a < MaxAxes; a++) begin : g_field
    if (a < AXES) begin : g_used
      logic signed [ExtW-1:0] ext_min, ext_max;
      assign ext_min = ExtW'(nmin[a]);
      assign ext_max = ExtW'(nmax[a]);
      assign fmin[a] = ext_min[FieldW-1:0];
      assign fmax[a] = ext_max[FieldW-1:0];
    end else begin : g_zero
      assign fmin[a] = '0;
      assign fmax[a] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        run_min_q[a] <= CoordMax;
        run_max_q[a] <= CoordMin;
      end
    end else if (drain_i) begin
      for (int a = 0; a < AXES; a++) begin
        run_min_q[a] <= last_i ? CoordMax : nmin[a];
        run_max_q[a] <= last_i ? CoordMin : nmax[a];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (drain_i && last_i) begin
      out_valid_d = 1'b1;
    end else if (box_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain_i && last_i) begin
      box_min_q <= fmin;
      box_max_q <= fmax;
    end
  end

  assign box_o.valid = out_valid_q;
  assign box_o.min_x = box_min_q[0];
  assign box_o.min_y = box_min_q[1];
  assign box_o.min_z = box_min_q[2];
  assign box_o.max_x = box_max_q[0];
  assign box_o.max_y = box_max_q[1];
  assign box_o.max_z = box_max_q[2];

endmodule

FILE: sim/quantized_vertex_bounding_box_tb.sv
module quantized_vertex_bounding_box_tb;
  import qvbb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     ResetCycles   = 10;
  localparam int     SettleCycles  = 8;
  localparam int     RandomItems   = 800;
  localparam int     IdlePct       = 11;
  localparam int     CalmFrom      = 500;
  localparam int     CalmTo        = 640;
  localparam int     HoldAfter     = 250;
  localparam int     HoldCycles    = 300;
  localparam int     WatchdogLimit = 2000;
  localparam longint SatHi         = 64'sd2147483647;
  localparam longint SatLo         = -SatHi - 1;
  localparam logic signed [FieldW-1:0] RunMinReset = 32'sh7FFF_FFFF;
  localparam logic signed [FieldW-1:0] RunMaxReset = 32'sh8000_0000;
  // index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgIdxNone = '1;

  typedef struct {
    logic signed [FieldW-1:0] min_x;
    logic signed [FieldW-1:0] min_y;
    logic signed [FieldW-1:0] min_z;
    logic signed [FieldW-1:0] max_x;
    logic signed [FieldW-1:0] max_y;
    logic signed [FieldW-1:0] max_z;
  } box_t;

  typedef struct {
    logic [CompW-1:0] comp_x;
    logic [CompW-1:0] comp_y;
    logic [CompW-1:0] comp_z;
    logic             last_vertex;
  } vertex_t;

  logic clk_i;
  logic rst_ni;

  qvbb_cfg_if cfg_if ();
  qvbb_vtx_if vtx_if ();
  qvbb_box_if box_if ();

  quantized_vertex_bounding_box dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .vtx_i  (vtx_if),
    .box_o  (box_if)
  );

  // predictor copy of the registers and running extents
  logic                     cfg_compressed;
  logic [DimsW-1:0]         cfg_dims;
  logic [ScaleW-1:0]        cfg_scale;
  logic signed [FieldW-1:0] cfg_offs [MaxAxes];
  logic signed [FieldW-1:0] run_min [MaxAxes];
  logic signed [FieldW-1:0] run_max [MaxAxes];

  vertex_t vertex_q [$];
  box_t    box_expect_q [$];
  box_t    box_exp;

  int mismatches;
  int vtx_accepted;
  int random_items;
  int hold_left;
  bit hold_done;
  int quiet_cycles;
  logic calm;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic signed [FieldW-1:0] axis_coord(logic signed [CompW-1:0] comp,
                                                          logic signed [FieldW-1:0] offs);
    longint acc;
    if (cfg_compressed) begin
      acc = longint'($signed(comp[CodeW-1:0])) * longint'(cfg_scale) + longint'(offs);
    end else begin
      acc = longint'(comp);
    end
    if (acc > SatHi) acc = SatHi;
    if (acc < SatLo) acc = SatLo;
    return acc[FieldW-1:0];
  endfunction

  function automatic void rearm_extents();
    for (int a = 0; a < MaxAxes; a++) begin
      run_min[a] = RunMinReset;
      run_max[a] = RunMaxReset;
    end
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [FieldW-1:0] data);
    case (idx)
      CFG_MODE:     cfg_compressed = data[0];
      CFG_DIMS:     cfg_dims = data[DimsW-1:0];
      CFG_SCALE:    cfg_scale = data;
      CFG_OFFSET_X: cfg_offs[0] = data;
      CFG_OFFSET_Y: cfg_offs[1] = data;
      CFG_OFFSET_Z: cfg_offs[2] = data;
      default: ;
    endcase
  endfunction

  // folds one accepted vertex; a last vertex closes the box
  function automatic void fold_vertex(logic [CompW-1:0] cx, logic [CompW-1:0] cy,
                                      logic [CompW-1:0] cz, logic last);
    logic signed [CompW-1:0]  comp [MaxAxes];
    logic signed [FieldW-1:0] v;
    box_t b;
    comp[0] = cx;
    comp[1] = cy;
    comp[2] = cz;
    for (int a = 0; a < MaxAxes; a++) begin
      v = (a < cfg_dims) ? axis_coord(comp[a], cfg_offs[a]) : '0;
      if (v < run_min[a]) run_min[a] = v;
      if (v > run_max[a]) run_max[a] = v;
    end
    if (last) begin
      b = '{run_min[0], run_min[1], run_min[2], run_max[0], run_max[1], run_max[2]};
      box_expect_q = {box_expect_q, b};
      rearm_extents();
    end
  endfunction

  function automatic void push_vertex(logic [CompW-1:0] cx, logic [CompW-1:0] cy,
                                      logic [CompW-1:0] cz, logic last);
    vertex_t v;
    v = '{cx, cy, cz, last};
    vertex_q = {vertex_q, v};
  endfunction

  function automatic logic [CompW-1:0] rand_comp();
    logic [CompW-1:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return {r[31:16], 16'h7FFF};
      3: return {r[31:16], 16'h8000};
      4, 5: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
      default: return r;
    endcase
  endfunction

  function automatic logic [ScaleW-1:0] rand_scale();
    case ($urandom_range(5))
      0: return 32'h0001_0000;
      1: return $urandom_range(32'h0004_0000);
      2: return $urandom_range(255);
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(32'h0100_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FieldW-1:0] rand_offset();
    case ($urandom_range(6))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3, 4: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic compare_field(input string name, input logic signed [FieldW-1:0] exp_v,
                               input logic signed [FieldW-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: %s expected %h got %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // call at a rising edge; valid stays high so back-to-back writes need no gap
  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [FieldW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_reg(idx, data);
  endtask

  task automatic set_config(input logic [FieldW-1:0] mode, input logic [FieldW-1:0] dims,
                            input logic [FieldW-1:0] scale, input logic [FieldW-1:0] ox,
                            input logic [FieldW-1:0] oy, input logic [FieldW-1:0] oz,
                            input bit poke_none);
    if (poke_none) reg_write(CfgIdxNone, $urandom);
    reg_write(CFG_MODE, mode);
    reg_write(CFG_DIMS, dims);
    reg_write(CFG_SCALE, scale);
    reg_write(CFG_OFFSET_X, ox);
    reg_write(CFG_OFFSET_Y, oy);
    reg_write(CFG_OFFSET_Z, oz);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // vertices without a last mark leave no box, hence the extra settle cycles
  task automatic drain_all();
    do @(negedge clk_i);
    while (vertex_q.size() != 0 || vtx_if.valid || box_expect_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_phase();
    int goal;
    int run;
    bit drop_tail;
    logic [FieldW-1:0] dims_data;
    dims_data = $urandom;
    dims_data[DimsW-1:0] = ($urandom_range(5) == 0) ? 2'd0 : DimsW'($urandom_range(1, 3));
    set_config($urandom, dims_data, rand_scale(), rand_offset(), rand_offset(),
               rand_offset(), $urandom_range(3) == 0);
    goal = $urandom_range(50, 90);
    random_items += goal;
    drop_tail = ($urandom_range(9) == 0);
    while (goal > 0) begin
      run = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      if (run > goal) run = goal;
      for (int k = 1; k <= run; k++) begin
        // an unfinished set carries its extents over into the next setting
        push_vertex(rand_comp(), rand_comp(), rand_comp(),
                    k == run && !(drop_tail && run == goal));
      end
      goal -= run;
    end
    drain_all();
  endtask

  assign calm = (vtx_accepted >= CalmFrom) && (vtx_accepted < CalmTo);

  // vertex driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_if.valid       <= 1'b0;
      vtx_if.comp_x      <= '0;
      vtx_if.comp_y      <= '0;
      vtx_if.comp_z      <= '0;
      vtx_if.last_vertex <= 1'b0;
      vtx_accepted       <= 0;
    end else begin
      if (vtx_if.valid && vtx_if.ready) begin
        fold_vertex(vtx_if.comp_x, vtx_if.comp_y, vtx_if.comp_z, vtx_if.last_vertex);
        vtx_accepted <= vtx_accepted + 1;
      end
      if (!vtx_if.valid || vtx_if.ready) begin
        if (vertex_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
          vtx_if.valid       <= 1'b1;
          vtx_if.comp_x      <= vertex_q[0].comp_x;
          vtx_if.comp_y      <= vertex_q[0].comp_y;
          vtx_if.comp_z      <= vertex_q[0].comp_z;
          vtx_if.last_vertex <= vertex_q[0].last_vertex;
          void'(vertex_q.pop_front());
        end else begin
          vtx_if.valid <= 1'b0;
        end
      end
    end
  end

  // one long back-pressure stretch while vertices keep coming
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && vtx_accepted >= HoldAfter && vertex_q.size() > 30) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // box monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_if.ready <= 1'b0;
    end else begin
      if (box_if.valid && box_if.ready) begin
        if (box_expect_q.size() == 0) begin
          $display("%0t ns: box with nothing expected, min %h %h %h max %h %h %h", $time,
                   box_if.min_x, box_if.min_y, box_if.min_z,
                   box_if.max_x, box_if.max_y, box_if.max_z);
          mismatches++;
        end else begin
          box_exp = box_expect_q.pop_front();
          compare_field("min_x", box_exp.min_x, box_if.min_x);
          compare_field("min_y", box_exp.min_y, box_if.min_y);
          compare_field("min_z", box_exp.min_z, box_if.min_z);
          compare_field("max_x", box_exp.max_x, box_if.max_x);
          compare_field("max_y", box_exp.max_y, box_if.max_y);
          compare_field("max_z", box_exp.max_z, box_if.max_z);
        end
      end
      box_if.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (vtx_if.valid && vtx_if.ready) || (box_if.valid && box_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    vtx_if.valid       = 1'b0;
    vtx_if.comp_x      = '0;
    vtx_if.comp_y      = '0;
    vtx_if.comp_z      = '0;
    vtx_if.last_vertex = 1'b0;
    box_if.ready       = 1'b0;
    mismatches         = 0;
    random_items       = 0;
    quiet_cycles       = 0;
    cfg_compressed     = 1'b0;
    cfg_dims           = DimsReset;
    cfg_scale          = ScaleReset;
    cfg_offs           = '{default: '0};
    rearm_extents();

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: raw coordinates, extremes, then a one-vertex set
    push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
    push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    drain_all();

    // widest step and extreme offsets: saturates both ways
    set_config(32'h1, 32'h3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
    push_vertex(32'h0000_7FFF, 32'h0000_8000, 32'h0000_0001, 1'b0);
    push_vertex(32'hFFFF_8000, 32'h1234_7FFF, 32'hABCD_FFFF, 1'b1);
    drain_all();

    // zero step: box collapses onto the offsets, z unused
    set_config(32'hFFFF_FFFF, 32'h2, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0);
    push_vertex($urandom, $urandom, $urandom, 1'b0);
    push_vertex($urandom, $urandom, $urandom, 1'b1);
    drain_all();

    // no dimension used: every axis reads zero; upper data bits ignored
    set_config(32'hFFFF_FFFE, 32'hFFFF_FFFC, 32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 1'b0);
    push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
    push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    drain_all();

    // single axis, unit step, negative offset; write to an unmapped index too
    set_config(32'h1, 32'h1, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 1'b1);
    push_vertex(32'hDEAD_0003, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_vertex(32'h0000_FFFD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    drain_all();

    set_config(32'h0, 32'h3, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b0);
    for (int k = 1; k <= 8; k++) push_vertex(rand_comp(), rand_comp(), rand_comp(), k == 8);
    drain_all();

    while (random_items < RandomItems) random_phase();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/qvbb_pkg.sv
rtl/qvbb_if.sv
rtl/qvbb_lane.sv
rtl/qvbb_merge.sv
rtl/quantized_vertex_bounding_box.sv
sim/quantized_vertex_bounding_box_tb.sv
